@@ hw/rtl/fba_pkg.sv @@
// Shared types and constants of the fixed-size block free-list allocator.
package fba_pkg;

  localparam int IDX_W  = 8;
  localparam int SIZE_W = 16;
  localparam int OFS_W  = 24;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_BLOCK_SIZE  = 1'b1;

  localparam logic [IDX_W-1:0]  BLOCK_COUNT_RST = 8'd255;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd8;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] block_index;
  } fba_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [OFS_W-1:0] byte_offset;
    logic [IDX_W-1:0] free_count;
  } fba_out_t;

  typedef struct packed {
    logic [IDX_W-1:0]  block_count;
    logic [SIZE_W-1:0] block_size;
  } fba_cfg_t;

endpackage

@@ hw/rtl/fba_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/fba_link_store.sv @@
// Link memory of the free list with per-entry valid bits for the reset chain.
module fba_link_store
  import fba_pkg::*;
#(
  parameter int DEPTH = 255
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [IDX_W-1:0]                        rd_data,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [IDX_W-1:0]                        wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic             rd_valid_r;
  logic [AW-1:0]    rd_addr_r;
  logic [IDX_W-1:0] ram_q;

  fba_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_valid_r <= valid_r[rd_addr];
      rd_addr_r  <= rd_addr;
    end
  end

  // An entry never written since reset still holds its reset link, index plus one.
  assign rd_data = rd_valid_r ? ram_q : IDX_W'(rd_addr_r) + IDX_W'(1);

endmodule

@@ hw/rtl/fba_apb_regs.sv @@
// APB configuration registers: block count and block size.
module fba_apb_regs
  import fba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output fba_cfg_t          cfg
);

  fba_cfg_t cfg_r;
  fba_cfg_t cfg_nxt;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (paddr[2])
        REG_BLOCK_COUNT: cfg_nxt.block_count = pwdata[IDX_W-1:0];
        REG_BLOCK_SIZE:  cfg_nxt.block_size  = pwdata[SIZE_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_count <= BLOCK_COUNT_RST;
      cfg_r.block_size  <= BLOCK_SIZE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BLOCK_COUNT: prdata = APB_DW'(cfg_r.block_count);
      REG_BLOCK_SIZE:  prdata = APB_DW'(cfg_r.block_size);
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/fixed_block_free_list_allocator.sv @@
// Fixed-size block free-list allocator: one command in, exactly one result beat out.
// A command is taken when start is high and busy is low; its result appears on
// out_result for one cycle with out_valid, and the receiver cannot stall it.
// Free, the unused command and an allocate that finds the pool empty finish in the
// cycle they are accepted; any other allocate goes on into the S_ALLOC state because
// the link of the head block comes out of a memory with a registered read.
// Reinitialize rewrites one link per cycle for block_count links (capped at
// MAX_BLOCKS), none when block_count is zero. The result beat follows in the cycle
// after the last cycle of the command. The link memory needs no clearing pass after
// reset: per-entry valid bits give the reset chain until an entry is written.
module fixed_block_free_list_allocator
  import fba_pkg::*;
#(
  parameter int MAX_BLOCKS = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fba_in_t           in_item,
  output logic              out_valid,
  output fba_out_t          out_result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;
  localparam logic [1:0] S_INIT  = 2'd2;

  fba_cfg_t         cfg;
  logic [IDX_W-1:0] n_eff;
  logic             accept;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] free_r, free_nxt;
  logic [IDX_W-1:0] sweep_r, sweep_nxt;
  fba_out_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [IDX_W-1:0] rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic [OFS_W-1:0] offset;

  fba_apb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fba_link_store #(.DEPTH(MAX_BLOCKS)) u_links (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign n_eff  = (cfg.block_count > IDX_W'(MAX_BLOCKS)) ? IDX_W'(MAX_BLOCKS)
                                                          : cfg.block_count;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign offset = OFS_W'(head_r) * OFS_W'(cfg.block_size);

  // Reads and writes of the link memory never overlap on one entry: busy holds
  // off the next command while an allocate waits for its read data.
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    sweep_nxt     = sweep_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = head_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = in_item.block_index[AW-1:0];
    wr_data       = head_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.status        = ST_OK;
          out_nxt.granted_index = '0;
          out_nxt.byte_offset   = '0;
          out_nxt.free_count    = free_r;
          case (in_item.command)
            CMD_ALLOC: begin
              if (free_r == '0 || head_r >= n_eff) begin
                out_nxt.status = ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_ALLOC;
              end
            end
            CMD_FREE: begin
              if (in_item.block_index >= n_eff) begin
                out_nxt.status = ST_RANGE;
              end else begin
                wr_en    = 1'b1;
                head_nxt = in_item.block_index;
                free_nxt = (free_r == '1) ? free_r : free_r + IDX_W'(1);
                out_nxt.free_count = free_nxt;
              end
              out_valid_nxt = 1'b1;
            end
            CMD_REINIT: begin
              if (n_eff == '0) begin
                head_nxt           = '0;
                free_nxt           = '0;
                out_nxt.free_count = '0;
                out_valid_nxt      = 1'b1;
              end else begin
                sweep_nxt = '0;
                state_nxt = S_INIT;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        head_nxt                = rd_data;
        free_nxt                = free_r - IDX_W'(1);
        out_nxt.status          = ST_OK;
        out_nxt.granted_index   = head_r;
        out_nxt.byte_offset     = offset;
        out_nxt.free_count      = free_nxt;
        out_valid_nxt           = 1'b1;
        state_nxt               = S_IDLE;
      end
      S_INIT: begin
        wr_en   = 1'b1;
        wr_addr = sweep_r[AW-1:0];
        wr_data = sweep_r + IDX_W'(1);
        if (sweep_r == n_eff - IDX_W'(1)) begin
          head_nxt              = '0;
          free_nxt              = n_eff;
          out_nxt.status        = ST_OK;
          out_nxt.granted_index = '0;
          out_nxt.byte_offset   = '0;
          out_nxt.free_count    = n_eff;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      free_r      <= BLOCK_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sweep_r <= sweep_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while a command is still in progress");

  a_alloc_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |=> out_valid && state_r == S_IDLE)
    else $error("allocate did not finish one cycle after its link read");

  a_free_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.command == CMD_FREE |=> out_valid && !busy)
    else $error("free did not produce its result in the next cycle");

  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.status != ST_OK |->
      out_result.granted_index == '0 && out_result.byte_offset == '0)
    else $error("failed command reported a granted block");

  a_init_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> sweep_r < n_eff)
    else $error("reinitialize sweep ran past the block count");

endmodule
